// ===== rtl/core/sfa_cq_pkg.sv =====
// Shared types and constants for the SFA coefficient quantizer.
// No dependencies; imported by sfa_cq_search and sfa_coefficient_quantizer_unit.
package sfa_cq_pkg;

   // Fixed field widths of the transaction ports
   localparam int SEG_FIELD_W  = 4;
   localparam int SEG_FIELDS   = 1 << SEG_FIELD_W;
   localparam int BIDX_FIELD_W = 8;
   localparam int COEFF_W      = 32;
   localparam int SYMBOL_W     = 8;
   localparam int BCOUNT_W     = 8;
   localparam int WLEN_W       = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;

   // Request kinds
   localparam logic REQ_WRITE    = 1'b0;
   localparam logic REQ_QUANTIZE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_LENGTH = 2'd1;

   // Register reset values
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 8'd3;
   localparam logic [WLEN_W-1:0]   WLEN_RESET   = 5'd8;

   // One result transaction
   typedef struct packed {
      logic [SYMBOL_W-1:0]    symbol;
      logic [SEG_FIELD_W-1:0] segment;
      logic                   last;
   } result_type;

endpackage

// ===== rtl/core/sfa_cq_mem.sv =====
// Boundary table storage: one write port, one read port, registered read.
// Depends on nothing but its parameters.
module sfa_cq_mem #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sfa_cq_search.sv =====
// Transaction sequencer and shared compare unit: binary search over one
// segment's boundaries, each probe a PROBE then a CMP state. Uses sfa_cq_pkg.
module sfa_cq_search
   import sfa_cq_pkg::*;
#(
   parameter int MAX_SEGMENTS   = 16,
   parameter int MAX_BOUNDARIES = 256,
   parameter int VALUE_WIDTH    = 32,
   parameter int SEG_W          = 4,
   parameter int CNT_W          = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [SEG_FIELD_W-1:0]     req_segment,
   input  logic [BIDX_FIELD_W-1:0]    req_boundary_index,
   input  logic signed [COEFF_W-1:0]  req_coeff_value,
   // configuration
   input  logic [BCOUNT_W-1:0]        bin_limit,
   input  logic [WLEN_W-1:0]          word_length,
   // table access
   output logic                       mem_wr_en,
   output logic [SEG_W+CNT_W-1:0]     mem_wr_addr,
   output logic [VALUE_WIDTH-1:0]     mem_wr_data,
   output logic                       mem_rd_en,
   output logic [SEG_W+CNT_W-1:0]     mem_rd_addr,
   input  logic [VALUE_WIDTH-1:0]     mem_rd_data,
   // result
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output result_type                 rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [BIDX_FIELD_W:0] MAX_IDX = (BIDX_FIELD_W + 1)'(MAX_BOUNDARIES - 1);

   logic [1:0]                     state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic [SEG_W-1:0]               seg_ff, seg_in;
   logic [SEG_FIELD_W-1:0]         seg_field_ff, seg_field_in;
   logic [CNT_W-1:0]               low_ff, low_in;
   logic [CNT_W-1:0]               high_ff, high_in;
   logic [CNT_W-1:0]               mid_ff, mid_in;
   result_type                     result_ff, result_in;

   logic [SEG_W-1:0]               seg_lut [SEG_FIELDS];
   logic [SEG_W-1:0]               req_seg;
   logic signed [VALUE_WIDTH-1:0]  req_key;
   logic [CNT_W-1:0]               count_sat;
   logic                           accept;
   logic                           below;

   // segment field wraps onto the table rows
   for (genvar g = 0; g < SEG_FIELDS; g++) begin : g_seg_lut
      assign seg_lut[g] = SEG_W'(g % MAX_SEGMENTS);
   end

   assign req_seg   = seg_lut[req_segment];
   assign req_key   = VALUE_WIDTH'(req_coeff_value);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // boundary count saturates at the table size minus one
   assign count_sat = ({1'b0, bin_limit} > MAX_IDX) ? CNT_W'(MAX_IDX)
                                                   : CNT_W'(bin_limit);

   // boundary writes below index MAX_IDX go straight to the table at acceptance
   assign mem_wr_en   = accept && (req_type == REQ_WRITE) &&
                        ({1'b0, req_boundary_index} < MAX_IDX);
   assign mem_wr_addr = {req_seg, req_boundary_index[CNT_W-1:0]};
   assign mem_wr_data = req_key;

   // shared compare: key below probed boundary
   assign below = key_ff < $signed(mem_rd_data);

   assign mem_rd_addr = {seg_ff, mid_in};
   assign mem_rd_en   = (state_ff == ST_PROBE) && (low_ff < high_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      seg_in       = seg_ff;
      seg_field_in = seg_field_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = low_ff + ((high_ff - low_ff) >> 1);
      result_in    = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_QUANTIZE)) begin
               key_in       = req_key;
               seg_in       = req_seg;
               seg_field_in = req_segment;
               low_in       = '0;
               high_in      = count_sat;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (low_ff < high_ff) begin
               state_in = ST_CMP;
            end else begin
               result_in.symbol  = SYMBOL_W'(low_ff);
               result_in.segment = seg_field_ff;
               result_in.last    = (WLEN_W'(seg_field_ff) + WLEN_W'(1)) == word_length;
               state_in          = ST_DONE;
            end
         end
         ST_CMP: begin
            mid_in = mid_ff;
            if (below) begin
               high_in = mid_ff;
            end else begin
               low_in = mid_ff + CNT_W'(1);
            end
            state_in = ST_PROBE;
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      seg_ff       <= seg_in;
      seg_field_ff <= seg_field_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      result_ff    <= result_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp       = result_ff;

endmodule

// ===== rtl/core/sfa_coefficient_quantizer_unit.sv =====
// Order: a write goes to the table at acceptance; a quantize result is valid
// once P probes (each a PROBE then a CMP state) and a final PROBE state have
// run, P = probes, at most ceil(log2(bin_limit + 1)) <= 8. One transaction at
// a time: no new request is taken until the result is accepted (rsp_ready).
// Reset (synchronous, active high) clears the sequencer and restores the
// registers; the boundary table holds no defined value until written.
// Top level: configuration registers, boundary table and search sequencer.
// Depends on sfa_cq_pkg, sfa_cq_mem and sfa_cq_search.
module sfa_coefficient_quantizer_unit
   import sfa_cq_pkg::*;
#(
   parameter int MAX_SEGMENTS   = 16,
   parameter int MAX_BOUNDARIES = 256,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [SEG_FIELD_W-1:0]    req_segment,
   input  logic [BIDX_FIELD_W-1:0]   req_boundary_index,
   input  logic signed [COEFF_W-1:0] req_coeff_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SYMBOL_W-1:0]       rsp_symbol,
   output logic [SEG_FIELD_W-1:0]    rsp_segment,
   output logic                      rsp_last
);

   localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_BOUNDARIES);
   localparam int ADDR_W = SEG_W + CNT_W;

   logic [BCOUNT_W-1:0]    bin_limit_ff, bin_limit_in;
   logic [WLEN_W-1:0]      word_length_ff, word_length_in;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [VALUE_WIDTH-1:0] mem_rd_data;
   result_type             rsp;

   // configuration register writes
   always_comb begin
      bin_limit_in   = bin_limit_ff;
      word_length_in = word_length_ff;
      if (csr_we) begin
         if (csr_index == CSR_BIN_LIMIT) begin
            bin_limit_in = BCOUNT_W'(csr_wdata);
         end else if (csr_index == CSR_WORD_LENGTH) begin
            word_length_in = csr_wdata[WLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_limit_ff   <= BCOUNT_RESET;
         word_length_ff <= WLEN_RESET;
      end else begin
         bin_limit_ff   <= bin_limit_in;
         word_length_ff <= word_length_in;
      end
   end

   // boundary table
   sfa_cq_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // search sequencer
   sfa_cq_search #(
      .MAX_SEGMENTS   (MAX_SEGMENTS),
      .MAX_BOUNDARIES (MAX_BOUNDARIES),
      .VALUE_WIDTH    (VALUE_WIDTH),
      .SEG_W          (SEG_W),
      .CNT_W          (CNT_W)
   ) u_search (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_segment        (req_segment),
      .req_boundary_index (req_boundary_index),
      .req_coeff_value    (req_coeff_value),
      .bin_limit          (bin_limit_ff),
      .word_length        (word_length_ff),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp                (rsp)
   );

   assign rsp_symbol  = rsp.symbol;
   assign rsp_segment = rsp.segment;
   assign rsp_last    = rsp.last;

endmodule
